// ===== rtl/lookahead_peak_limiter_unit_defines.svh =====
// Assertion macros shared by the limiter RTL.
`ifndef LOOKAHEAD_PEAK_LIMITER_UNIT_DEFINES_SVH
`define LOOKAHEAD_PEAK_LIMITER_UNIT_DEFINES_SVH

// Check a condition at every edge outside reset.
`define LLIM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence on the next edge.
`define LLIM_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/llim_pkg.sv =====
// Package: shared types and constants of the look-ahead peak limiter.
`timescale 1ns / 1ps
package llim_pkg;

  localparam int unsigned MUL_W = 41;

  localparam logic [15:0] Q_ONE = 16'h8000;
  localparam logic [MUL_W-1:0] Q_HALF = MUL_W'(16384);

  localparam logic [14:0] THRESH_RST  = 15'd32767;
  localparam logic [15:0] ATTACK_RST  = 16'd983;
  localparam logic [15:0] RELEASE_RST = 16'd33;

  typedef enum logic [1:0] {
    REG_THRESH  = 2'd0,
    REG_ATTACK  = 2'd1,
    REG_RELEASE = 2'd2
  } llim_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PK_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_G_MUL,
    ST_O_GO,
    ST_O_MUL,
    ST_DONE
  } llim_state_t;

endpackage

// ===== rtl/llim_ifs.sv =====
// Interfaces: input and result word channels of the limiter.
`timescale 1ns / 1ps
interface llim_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface llim_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/llim_mul.sv =====
// Shift-add multiplier: signed multiplicand times 16-bit unsigned, one bit a cycle.
`timescale 1ns / 1ps
module llim_mul
  import llim_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [24:0]      mcand,
  input  logic        [15:0]      mplier,
  output logic                    done,
  output logic signed [MUL_W-1:0] prod
);

  logic signed [MUL_W-1:0] acc_r, acc_nxt;
  logic signed [MUL_W-1:0] mc_r, mc_nxt;
  logic        [15:0]      mp_r, mp_nxt;
  logic        [3:0]       cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  // Add the shifted multiplicand for each set multiplier bit
  always_comb begin
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      mc_nxt   = MUL_W'(mcand);
      mp_nxt   = mplier;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt  = mc_r <<< 1;
      mp_nxt  = mp_r >> 1;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/llim_div.sv =====
// Restoring divider: target gain = min(1, threshold * 2^23 / peak), one bit a cycle.
`timescale 1ns / 1ps
module llim_div
  import llim_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [14:0] thresh,
  input  logic [23:0] peak,
  output logic        done,
  output logic [15:0] quo
);

  logic [24:0] rem_r, rem_nxt;
  logic [16:0] q_r, q_nxt;
  logic [23:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [24:0] rem_sh;
  logic [20:0] num_hi;

  assign num_hi = {thresh, 6'b0};
  assign rem_sh = {rem_r[23:0], 1'b0};

  // Shift in one quotient bit a cycle; a zero peak or a wide quotient clamps at once
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvs_nxt = peak;
      cnt_nxt = '0;
      if (24'(num_hi) >= peak) begin
        q_nxt    = 17'(Q_ONE);
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = 25'(num_hi);
        q_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = (q_r > 17'(Q_ONE)) ? Q_ONE : q_r[15:0];

endmodule

// ===== rtl/lookahead_peak_limiter_unit.sv =====
// Top level: look-ahead peak limiter with APB-style register port.
`timescale 1ns / 1ps
`include "lookahead_peak_limiter_unit_defines.svh"
// Look-ahead peak limiter. Each input word is one signed 16-bit sample, and
// each one produces one output word: the sample LOOKAHEAD_DEPTH words older,
// scaled by the smoothed gain, rounded and saturated. Each item passes through
// a 16-step shift-add multiply for the peak follower, a 17-step restoring
// divide for the target gain, a 16-step multiply for gain smoothing and a
// 16-step multiply for the output, all on one serial multiplier, with
// handover states between them. A zero peak, or a peak small enough that the
// gain clamps to unity, skips the divide steps. One item is in flight at a
// time. The next word can be accepted in the same cycle that the output word
// is first presented, and it is taken while a finished word still waits at
// the output. The delay line is a memory with one fill flag, so no clearing
// pass follows reset.
// Registers: 0x0 threshold (15 bits), 0x4 attack coefficient, 0x8 release
// coefficient (Q1.15, values above 0x8000 saturate to 0x8000).
module lookahead_peak_limiter_unit
  import llim_pkg::*;
#(
  parameter int unsigned LOOKAHEAD_DEPTH = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  llim_in_if.sink           in_word,
  llim_out_if.source        out_word,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned PTR_W = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;

  llim_state_t state_r, state_nxt;

  logic [14:0] thresh_r;
  logic [15:0] attack_r;
  logic [15:0] release_r;
  logic [23:0] peak_r, peak_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic signed [15:0] res_r, res_nxt;
  logic signed [15:0] out_data_r;
  logic        out_valid_r, out_valid_nxt;

  logic signed [15:0] line_mem [LOOKAHEAD_DEPTH];
  logic [PTR_W-1:0]   ptr_r;
  logic               fill_r;
  logic signed [15:0] rd_q_r;
  logic               rd_zero_r;

  logic                    in_acc;
  logic                    wr_en;
  logic [1:0]              wr_idx;
  logic [15:0]             wr_coef;
  logic                    mul_start;
  logic signed [24:0]      mul_mcand;
  logic [15:0]             mul_mplier;
  logic                    mul_done;
  logic signed [MUL_W-1:0] mul_prod;
  logic signed [MUL_W-1:0] mul_rnd;
  logic signed [25:0]      mul_sh;
  logic                    div_start;
  logic                    div_done;
  logic [15:0]             div_quo;
  logic [16:0]             mag;
  logic [23:0]             mag8;

  // Register port: write on the access phase, read the selected register
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign wr_idx     = cfg_paddr[3:2];
  assign wr_coef    = (cfg_pwdata[15:0] > Q_ONE) ? Q_ONE : cfg_pwdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      attack_r  <= ATTACK_RST;
      release_r <= RELEASE_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_THRESH:  thresh_r  <= cfg_pwdata[14:0];
        REG_ATTACK:  attack_r  <= wr_coef;
        REG_RELEASE: release_r <= wr_coef;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_THRESH:  cfg_prdata = {17'd0, thresh_r};
      REG_ATTACK:  cfg_prdata = {16'd0, attack_r};
      REG_RELEASE: cfg_prdata = {16'd0, release_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // Input word and its magnitude in 16.8 form
  assign in_word.ready = (state_r == ST_IDLE);
  assign in_acc        = in_word.valid && in_word.ready;
  assign mag  = in_word.sample_in[15] ? 17'(-$signed({in_word.sample_in[15], in_word.sample_in}))
                                      : {1'b0, in_word.sample_in};
  assign mag8 = {mag[15:0], 8'd0};

  // Delay line: read the oldest word, then overwrite it with the new one
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_q_r             <= line_mem[ptr_r];
      line_mem[ptr_r]    <= in_word.sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= 1'b0;
    end else if (in_acc) begin
      if (ptr_r == PTR_W'(LOOKAHEAD_DEPTH - 1)) begin
        ptr_r  <= '0;
        fill_r <= 1'b1;
      end else begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_zero_r <= !fill_r;
    end
  end

  // Rounded product, scaled back by 2^15
  assign mul_rnd = mul_prod + $signed(Q_HALF);
  assign mul_sh  = 26'(mul_rnd >>> 15);

  // Sequencer: peak blend, divide, gain blend, output scale
  always_comb begin
    state_nxt     = state_r;
    peak_nxt      = peak_r;
    gain_nxt      = gain_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    mul_start     = 1'b0;
    mul_mcand     = '0;
    mul_mplier    = '0;
    div_start     = 1'b0;
    if (out_valid_r && out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mul_start  = 1'b1;
          mul_mcand  = $signed({1'b0, mag8}) - $signed({1'b0, peak_r});
          mul_mplier = (mag8 > peak_r) ? attack_r : release_r;
          state_nxt  = ST_PK_MUL;
        end
      end
      ST_PK_MUL: begin
        if (mul_done) begin
          peak_nxt  = 24'($signed({2'b0, peak_r}) + mul_sh);
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          mul_start  = 1'b1;
          mul_mcand  = 25'($signed({1'b0, div_quo}) - $signed({1'b0, gain_r}));
          mul_mplier = (div_quo < gain_r) ? attack_r : release_r;
          state_nxt  = ST_G_MUL;
        end
      end
      ST_G_MUL: begin
        if (mul_done) begin
          gain_nxt  = 16'($signed({10'b0, gain_r}) + mul_sh);
          state_nxt = ST_O_GO;
        end
      end
      ST_O_GO: begin
        mul_start  = 1'b1;
        mul_mcand  = rd_zero_r ? 25'sd0 : 25'(rd_q_r);
        mul_mplier = gain_r;
        state_nxt  = ST_O_MUL;
      end
      ST_O_MUL: begin
        if (mul_done) begin
          if (mul_sh > 26'sd32767) begin
            res_nxt = 16'sh7FFF;
          end else if (mul_sh < -26'sd32768) begin
            res_nxt = -16'sh8000;
          end else begin
            res_nxt = 16'(mul_sh);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_word.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      peak_r      <= '0;
      gain_r      <= Q_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      peak_r      <= peak_nxt;
      gain_r      <= gain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the result and load the output register when the slot is free
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_word.ready)) begin
      out_data_r <= res_r;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.sample_out = out_data_r;

  llim_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  llim_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .thresh (thresh_r),
    .peak   (peak_r),
    .done   (div_done),
    .quo    (div_quo)
  );

  `LLIM_ASSERT_ALWAYS(a_gain_max, gain_r <= Q_ONE, "smoothed gain above unity")
  `LLIM_ASSERT_ALWAYS(a_peak_max, peak_r <= 24'h800000, "peak follower above full scale")
  `LLIM_ASSERT_NEXT(a_acc_busy, in_acc, state_r == ST_PK_MUL, "accepted word did not start")
  `LLIM_ASSERT_NEXT(a_out_load, state_r == ST_DONE && !out_valid_r, out_valid_r,
                    "finished word not presented")

endmodule
